// ===== rtl/thdb_pkg.sv =====
// Package with shared types and constants of the text hash duplicate bitmap unit.
`timescale 1ns / 1ps

package thdb_pkg;

  // Size of the bit table; the hash always stays below this value.
  localparam int TABLE_BITS  = 1048576;
  localparam int HASH_W      = $clog2(TABLE_BITS);
  localparam int TABLE_BYTES = (TABLE_BITS + 7) / 8;
  localparam int ADDR_W      = $clog2(TABLE_BYTES);

  // Configuration register and the clamped modulus.
  localparam int CFG_W       = 21;
  localparam int M_W         = HASH_W + 1;
  localparam int CLAMP_W     = (CFG_W > M_W) ? CFG_W : M_W;
  localparam int CMP_W       = HASH_W + 3;
  localparam int MOD_MIN     = 8;
  localparam int MOD_RST_RAW = 1048576;
  localparam int MOD_RST     = (MOD_RST_RAW > TABLE_BITS) ? TABLE_BITS : MOD_RST_RAW;

  // Hash update: value = hash * HASH_MUL + byte, then reduced.
  localparam int CHAR_W      = 8;
  localparam int HASH_MUL    = 23;
  localparam int CHAR_LOW    = 65;
  localparam int CHAR_HIGH   = 122;
  localparam int VAL_W       = HASH_W + 5;
  localparam int X_W         = VAL_W + (VAL_W % 2);
  localparam int FULL_STEPS  = X_W / 2;
  localparam int FAST_BITS   = 6;
  localparam int FAST_STEPS  = FAST_BITS / 2;
  localparam int CNT_W       = $clog2(FULL_STEPS + 1);

  // Request to the reduction unit.
  typedef struct packed {
    logic             start;
    logic             full;
    logic [VAL_W-1:0] value;
  } hash_req_t;

  // Answer of the reduction unit.
  typedef struct packed {
    logic              done;
    logic [HASH_W-1:0] hash;
  } hash_rsp_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_RESP
  } thdb_state_e;

endpackage

// ===== rtl/thdb_if.sv =====
// Channel interfaces of the text hash duplicate bitmap unit.
`timescale 1ns / 1ps

interface thdb_text_if;
  logic                        valid;
  logic                        ready;
  logic [thdb_pkg::CHAR_W-1:0] text_byte;
  logic                        last;

  modport source (output valid, output text_byte, output last, input ready);
  modport sink (input valid, input text_byte, input last, output ready);
endinterface

interface thdb_result_if;
  logic valid;
  logic ready;
  logic is_new;

  modport source (output valid, output is_new, input ready);
  modport sink (input valid, input is_new, output ready);
endinterface

interface thdb_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [thdb_pkg::CFG_W-1:0] hash_modulus;

  modport source (output valid, output hash_modulus, input ready);
  modport sink (input valid, input hash_modulus, output ready);
endinterface

// ===== rtl/text_hash_duplicate_bitmap_unit.sv =====
// Top level: hashes document characters and tests-and-sets a bit per document.
// A hashed character is accepted and then reduced in 3 steps; the first hashed
// character after a modulus write takes 13 steps of the radix-4 reduction unit.
// A character outside 'A'..'z' is accepted without a reduction; a last character adds the
// bit table write-back through the one RAM port, whose result sits in an output register.
// After reset the bit table is cleared one byte per cycle before input is taken.
`timescale 1ns / 1ps

module text_hash_duplicate_bitmap_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  thdb_cfg_if.sink             cfg_i,
  thdb_text_if.sink            text_i,
  thdb_result_if.source        result_o
);

  thdb_pkg::thdb_state_e              state_q, state_d;
  logic [thdb_pkg::HASH_W-1:0]        hash_q, hash_d;
  logic                               last_q, last_d;
  logic                               big_q, big_d;
  logic [thdb_pkg::ADDR_W-1:0]        clr_q, clr_d;
  logic                               out_valid_q, out_valid_d;
  logic                               is_new_q, is_new_d;
  logic [thdb_pkg::M_W-1:0]           m_q;
  logic [thdb_pkg::CMP_W-1:0]         m3_q;

  logic [thdb_pkg::CLAMP_W-1:0]       cfg_ext;
  logic [thdb_pkg::M_W-1:0]           m_new;
  logic                               cfg_wr;
  logic                               in_acc;
  logic                               hashed;
  logic [thdb_pkg::VAL_W-1:0]         upd_val;

  thdb_pkg::hash_req_t                hreq;
  thdb_pkg::hash_rsp_t                hrsp;

  logic                               ram_en;
  logic                               ram_we;
  logic [thdb_pkg::ADDR_W-1:0]        ram_addr;
  logic [7:0]                         ram_wdata;
  logic [7:0]                         ram_rdata;
  logic [7:0]                         bit_mask;

  // Configuration beat: clamp the modulus into the table range.
  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid && cfg_i.ready;
  assign cfg_ext     = thdb_pkg::CLAMP_W'(cfg_i.hash_modulus);

  always_comb begin
    if (cfg_ext < thdb_pkg::CLAMP_W'(thdb_pkg::MOD_MIN)) begin
      m_new = thdb_pkg::M_W'(thdb_pkg::MOD_MIN);
    end else if (cfg_ext > thdb_pkg::CLAMP_W'(thdb_pkg::TABLE_BITS)) begin
      m_new = thdb_pkg::M_W'(thdb_pkg::TABLE_BITS);
    end else begin
      m_new = thdb_pkg::M_W'(cfg_ext);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q  <= thdb_pkg::M_W'(thdb_pkg::MOD_RST);
      m3_q <= thdb_pkg::CMP_W'(3 * thdb_pkg::MOD_RST);
    end else if (cfg_wr) begin
      m_q  <= m_new;
      m3_q <= thdb_pkg::CMP_W'(m_new) + (thdb_pkg::CMP_W'(m_new) << 1);
    end
  end

  // Input beat decode and the unreduced hash update.
  assign in_acc  = text_i.valid && text_i.ready;
  assign hashed  = (text_i.text_byte >= thdb_pkg::CHAR_W'(thdb_pkg::CHAR_LOW)) &&
                   (text_i.text_byte <= thdb_pkg::CHAR_W'(thdb_pkg::CHAR_HIGH));
  assign upd_val = thdb_pkg::VAL_W'(hash_q) * thdb_pkg::VAL_W'(thdb_pkg::HASH_MUL) +
                   thdb_pkg::VAL_W'(text_i.text_byte);

  thdb_hash u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (hreq),
    .m_i    (m_q),
    .m3_i   (m3_q),
    .rsp_o  (hrsp)
  );

  thdb_ram #(
    .WIDTH (8),
    .DEPTH (thdb_pkg::TABLE_BYTES)
  ) u_table (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign bit_mask = 8'(1) << hash_q[2:0];

  // Sequencer: table clear, character intake, reduction wait, bit update.
  always_comb begin
    state_d     = state_q;
    hash_d      = hash_q;
    last_d      = last_q;
    big_d       = big_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q;
    is_new_d    = is_new_q;
    text_i.ready = 1'b0;
    hreq        = '0;
    hreq.full   = big_q;
    hreq.value  = upd_val;
    ram_en      = 1'b0;
    ram_we      = 1'b0;
    ram_addr    = clr_q;
    ram_wdata   = '0;

    if (result_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      thdb_pkg::ST_CLEAR: begin
        ram_en = 1'b1;
        ram_we = 1'b1;
        clr_d  = clr_q + thdb_pkg::ADDR_W'(1);
        if (clr_q == thdb_pkg::ADDR_W'(thdb_pkg::TABLE_BYTES - 1)) begin
          state_d = thdb_pkg::ST_IDLE;
        end
      end
      thdb_pkg::ST_IDLE: begin
        text_i.ready = 1'b1;
        if (in_acc) begin
          last_d = text_i.last;
          if (hashed) begin
            hreq.start = 1'b1;
            state_d    = thdb_pkg::ST_HASH;
          end else if (text_i.last) begin
            ram_en   = 1'b1;
            ram_addr = thdb_pkg::ADDR_W'(hash_q >> 3);
            state_d  = thdb_pkg::ST_RESP;
          end
        end
      end
      thdb_pkg::ST_HASH: begin
        if (hrsp.done) begin
          hash_d = hrsp.hash;
          big_d  = 1'b0;
          if (last_q) begin
            ram_en   = 1'b1;
            ram_addr = thdb_pkg::ADDR_W'(hrsp.hash >> 3);
            state_d  = thdb_pkg::ST_RESP;
          end else begin
            state_d = thdb_pkg::ST_IDLE;
          end
        end
      end
      thdb_pkg::ST_RESP: begin
        // Write back the set bit once the output register is free.
        if (!out_valid_q || result_o.ready) begin
          ram_en      = 1'b1;
          ram_we      = 1'b1;
          ram_addr    = thdb_pkg::ADDR_W'(hash_q >> 3);
          ram_wdata   = ram_rdata | bit_mask;
          out_valid_d = 1'b1;
          is_new_d    = (ram_rdata & bit_mask) == 8'd0;
          hash_d      = '0;
          big_d       = 1'b0;
          state_d     = thdb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = thdb_pkg::ST_IDLE;
      end
    endcase

    // A new modulus may leave the hash above it: reduce fully next time.
    if (cfg_wr) begin
      big_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= thdb_pkg::ST_CLEAR;
      hash_q      <= '0;
      last_q      <= 1'b0;
      big_q       <= 1'b0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hash_q      <= hash_d;
      last_q      <= last_d;
      big_q       <= big_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_new_q <= is_new_d;
  end

  assign result_o.valid  = out_valid_q;
  assign result_o.is_new = is_new_q;

endmodule

// ===== rtl/thdb_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
`timescale 1ns / 1ps

module thdb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write or read one entry; read data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/thdb_hash.sv =====
// Radix-4 restoring reduction of the hash update value by the modulus.
`timescale 1ns / 1ps

module thdb_hash (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  thdb_pkg::hash_req_t           req_i,
  input  logic [thdb_pkg::M_W-1:0]      m_i,
  input  logic [thdb_pkg::CMP_W-1:0]    m3_i,
  output thdb_pkg::hash_rsp_t           rsp_o
);

  logic                          busy_q, busy_d;
  logic [thdb_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic [thdb_pkg::X_W-1:0]      dq_q, dq_d;
  logic [thdb_pkg::HASH_W-1:0]   rem_q, rem_d;
  logic [thdb_pkg::CMP_W-1:0]    rem4;
  logic [thdb_pkg::CMP_W-1:0]    m1;
  logic [thdb_pkg::CMP_W-1:0]    m2;
  logic [thdb_pkg::CMP_W-1:0]    rem_next;

  assign m1 = thdb_pkg::CMP_W'(m_i);
  assign m2 = m1 << 1;

  // One quotient digit: bring down two bits and subtract the largest fitting multiple.
  always_comb begin
    rem4 = thdb_pkg::CMP_W'({rem_q, dq_q[thdb_pkg::X_W-1 -: 2]});
    if (rem4 >= m3_i) begin
      rem_next = rem4 - m3_i;
    end else if (rem4 >= m2) begin
      rem_next = rem4 - m2;
    end else if (rem4 >= m1) begin
      rem_next = rem4 - m1;
    end else begin
      rem_next = rem4;
    end
  end

  // Load a new value or advance one digit.
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      if (req_i.full) begin
        // The old hash may exceed the modulus: divide the whole value.
        cnt_d = thdb_pkg::CNT_W'(thdb_pkg::FULL_STEPS);
        dq_d  = thdb_pkg::X_W'(req_i.value);
        rem_d = '0;
      end else begin
        // The value is below 64 times the modulus: its upper part is already reduced.
        cnt_d = thdb_pkg::CNT_W'(thdb_pkg::FAST_STEPS);
        dq_d  = thdb_pkg::X_W'(req_i.value) << (thdb_pkg::X_W - thdb_pkg::FAST_BITS);
        rem_d = thdb_pkg::HASH_W'(req_i.value >> thdb_pkg::FAST_BITS);
      end
    end else if (busy_q) begin
      cnt_d = cnt_q - thdb_pkg::CNT_W'(1);
      dq_d  = dq_q << 2;
      rem_d = thdb_pkg::HASH_W'(rem_next);
      if (cnt_q == thdb_pkg::CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
  end

  // The final digit's remainder is the new hash.
  assign rsp_o.done = busy_q && (cnt_q == thdb_pkg::CNT_W'(1));
  assign rsp_o.hash = thdb_pkg::HASH_W'(rem_next);

endmodule
